// ----- design/cqs_pkg.sv -----
// ----------------------------------------------------------------------------
// cqs_pkg: shared types and codes for the circular queue with search
// Holds the command and status codes, the item and result transfer types,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

	// Width and reset value of the capacity register.
	localparam int unsigned CAP_W = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;
	localparam logic [1:0] CMD_DUMP   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] data;
		logic [2:0]         slot_index;
		logic               occupied;
		logic               last;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic do_insert;
		logic do_full;
		logic do_empty;
		logic do_delete;
		logic del_emit;
		logic scan_start;
		logic scan_run;
		logic scan_dump;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;
	} stat_t;

endpackage

`default_nettype wire

// ----- design/cqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cqs_ctrl: command sequencer of the circular queue
// Takes a command, decides the operation from the queue status and steps
// the datapath through the insert, delete or slot scan.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ctrl import cqs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire logic [1:0] cmd,
	input  wire stat_t stat,
	output ctl_t       ctl,
	output logic       busy
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEL_OUT,
		S_SCAN
	} state_t;

	state_t     state_q;
	logic [1:0] cmd_q;
	logic       is_scan_cmd;

	assign is_scan_cmd = (cmd_q == CMD_SEARCH) || (cmd_q == CMD_DUMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_INSERT;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						busy    <= 1'b1;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q == CMD_INSERT || stat.empty) begin
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end else if (cmd_q == CMD_DELETE) begin
						state_q <= S_DEL_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_DEL_OUT: begin
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (stat.scan_done) begin
						busy    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					busy    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl            = '0;
		ctl.load       = (state_q == S_IDLE) && start;
		ctl.scan_dump  = (cmd_q == CMD_DUMP);
		ctl.del_emit   = (state_q == S_DEL_OUT);
		ctl.scan_run   = (state_q == S_SCAN);
		if (state_q == S_EXEC) begin
			ctl.do_insert  = (cmd_q == CMD_INSERT) && !stat.full;
			ctl.do_full    = (cmd_q == CMD_INSERT) && stat.full;
			ctl.do_empty   = (cmd_q != CMD_INSERT) && stat.empty;
			ctl.do_delete  = (cmd_q == CMD_DELETE) && !stat.empty;
			ctl.scan_start = is_scan_cmd && !stat.empty;
		end
	end

endmodule

`default_nettype wire

// ----- design/cqs_datapath.sv -----
// ----------------------------------------------------------------------------
// cqs_datapath: slot memory, ring pointers and scan pipeline
// Holds the capacity register, head, tail and count, the slot memory with a
// registered read port, the one-slot-per-cycle scan and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_datapath import cqs_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_data,
	input  wire logic [31:0]      value,
	input  wire ctl_t             ctl,
	output stat_t                 stat,
	output out_t                  result,
	output logic                  result_valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int IW = AW + 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = IW + 1;
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
	localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

	logic [CAP_W-1:0] capacity_q;
	logic [EW-1:0]    cap_ext;
	logic [EW-1:0]    cap_sel;
	logic [CW-1:0]    cap_eff;
	logic [IW-1:0]    cap_i;

	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [31:0]   val_q;

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] rd_addr;
	logic [31:0]   rdata_s1;
	logic [AW-1:0] idx_s1;
	logic          vld_s1;
	logic [IW-1:0] scan_q;
	logic [IW-1:0] scan_limit;
	logic          issue;

	logic [IW-1:0] s_i;
	logic [IW-1:0] h_i;
	logic [DW-1:0] ring_off;
	logic          occ;
	logic          hit;
	logic          last_hit;
	logic          end_hit;

	out_t result_d;
	logic result_v_d;

	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] idx,
		input logic [IW-1:0] cap);
		logic [IW-1:0] n;
		n = IW'(idx) + IW'(1);
		return (n >= cap) ? '0 : AW'(n);
	endfunction

	// A capacity of zero acts as one, and one beyond the memory as DEPTH.
	assign cap_ext = EW'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			cap_sel = EW'(1);
		end else if (cap_ext > DEPTH_E) begin
			cap_sel = DEPTH_E;
		end else begin
			cap_sel = cap_ext;
		end
	end
	assign cap_eff = CW'(cap_sel);
	assign cap_i   = IW'(cap_eff);

	assign stat.full  = (count_q >= cap_eff);
	assign stat.empty = (count_q == '0);

	// Occupancy of the slot in the compare stage, taken from the walk of
	// count steps from head under the current capacity.
	assign s_i = IW'(idx_s1);
	assign h_i = IW'(head_q);
	always_comb begin
		ring_off = '0;
		if (h_i < cap_i) begin
			if (s_i >= h_i) begin
				ring_off = DW'(s_i - h_i);
			end else begin
				ring_off = DW'(s_i) + DW'(cap_i) - DW'(h_i);
			end
			occ = (s_i < cap_i) && (ring_off < DW'(count_q));
		end else begin
			occ = (idx_s1 == head_q) ||
				((s_i < cap_i) && (DW'(s_i) + DW'(1) < DW'(count_q)));
		end
	end

	assign hit      = occ && (rdata_s1 == val_q);
	assign last_hit = (s_i == cap_i - IW'(1));
	assign end_hit  = (s_i == LAST_SLOT);

	assign stat.scan_done = vld_s1 && (ctl.scan_dump ? last_hit : (hit || end_hit));

	assign scan_limit = ctl.scan_dump ? cap_i : IW'(DEPTH);
	assign issue      = ctl.scan_run && !stat.scan_done && (scan_q < scan_limit);
	assign rd_addr    = ctl.do_delete ? head_q : scan_q[AW-1:0];

	// Slot memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.do_insert) begin
			mem[tail_q] <= val_q;
		end
		rdata_s1 <= mem[rd_addr];
		idx_s1   <= scan_q[AW-1:0];
		if (ctl.load) begin
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			count_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			if (ctl.do_insert) begin
				tail_q  <= step_idx(tail_q, cap_i);
				count_q <= count_q + CW'(1);
			end else if (ctl.do_delete) begin
				count_q <= count_q - CW'(1);
				if (count_q == CW'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end else begin
					head_q <= step_idx(head_q, cap_i);
				end
			end
			if (ctl.scan_start) begin
				scan_q <= '0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					scan_q <= scan_q + IW'(1);
				end
			end
		end
	end

	always_comb begin
		result_d   = '0;
		result_v_d = 1'b0;
		if (ctl.do_full) begin
			result_d.status = ST_FULL;
			result_d.last   = 1'b1;
			result_v_d      = 1'b1;
		end else if (ctl.do_insert) begin
			result_d.status = ST_OK;
			result_d.last   = 1'b1;
			result_v_d      = 1'b1;
		end else if (ctl.do_empty) begin
			result_d.status = ST_EMPTY;
			result_d.last   = 1'b1;
			result_v_d      = 1'b1;
		end else if (ctl.del_emit) begin
			result_d.status = ST_OK;
			result_d.data   = rdata_s1;
			result_d.last   = 1'b1;
			result_v_d      = 1'b1;
		end else if (ctl.scan_run && vld_s1) begin
			if (ctl.scan_dump) begin
				result_d.status     = ST_OK;
				result_d.data       = occ ? rdata_s1 : '0;
				result_d.slot_index = 3'(idx_s1);
				result_d.occupied   = occ;
				result_d.last       = last_hit;
				result_v_d          = 1'b1;
			end else if (hit) begin
				result_d.status     = ST_OK;
				result_d.slot_index = 3'(idx_s1);
				result_d.last       = 1'b1;
				result_v_d          = 1'b1;
			end else if (end_hit) begin
				result_d.status = ST_NOTFOUND;
				result_d.last   = 1'b1;
				result_v_d      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		result <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= result_v_d;
		end
	end

`ifndef SYNTH
	a_empty_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with pointers away from slot zero");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_insert |-> (count_q < cap_eff))
		else $error("insert into a full ring");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count exceeds the slot memory");
`endif

endmodule

`default_nettype wire

// ----- design/circular_queue_with_search.sv -----
// ----------------------------------------------------------------------------
// circular_queue_with_search: ring-buffer queue of 32-bit words with search
// Top level: joins the command sequencer and the queue datapath.
// ----------------------------------------------------------------------------
//
// A command is transferred at a rising edge where start is high and busy is
// low; item carries the command code and the word. Insert adds the word at
// the tail or reports full, delete returns the oldest word or reports empty,
// search reports the lowest slot holding the word, and dump gives one result
// per ring slot with an occupied mark. Every result is shown on result for
// exactly one cycle with result_valid high; the receiver cannot stall, so it
// must take each transfer as it comes. The final result of a command has
// result.last set.
// Insert and any command on an empty queue end in the execute state; delete
// goes on through the delete output state. The scan reads one slot per cycle
// from the slot memory's single registered read port; a search stops at its
// first hit or at the last memory slot, and a dump of a ring of capacity C
// gives its C results back to back. The capacity register is written through
// cfg_we and cfg_data; the user must write it only while idle, as the block
// does not enforce this. Reset empties the queue, sets capacity to 5 and
// drops busy; slot contents are not cleared and never need to be.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_search import cqs_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire in_t              item,
	output out_t                  result,
	output logic                  result_valid,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_data
);

	ctl_t  ctl;
	stat_t stat;

	// The sequencer owns the command code and the phase of the operation.
	cqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// The datapath owns the word, the ring state and the result register.
	cqs_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.value        (item.value),
		.ctl          (ctl),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

`ifndef SYNTH
	a_result_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result transfer with no command in progress");

	a_dump_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> result_valid)
		else $error("gap inside a dump burst");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");
`endif

endmodule

`default_nettype wire
